FILE: hdl/wsat_pkg.sv
`timescale 1ns / 1ps
package wsat_pkg;
   localparam int NUM_REGS = 6;
   localparam logic [2:0] REG_W_PRESSURE = 3'd0;
   localparam logic [2:0] REG_W_VELOCITY = 3'd1;
   localparam logic [2:0] REG_W_SPREAD   = 3'd2;
   localparam logic [2:0] REG_W_DPRESS   = 3'd3;
   localparam logic [2:0] REG_W_DVEL     = 3'd4;
   localparam logic [2:0] REG_SIGMA      = 3'd5;
   localparam logic [15:0] WEIGHT_RESET  = 16'd819;
   localparam logic [15:0] SIGMA_RESET   = 16'd8192;
   localparam logic [12:0] ONE_Q12       = 13'd4096;
   localparam logic [15:0] THRESH_FLOOR  = 16'd819;

   typedef struct packed {
      logic signed [15:0] feat_pressure;
      logic signed [15:0] feat_velocity;
      logic signed [15:0] feat_spread;
      logic signed [15:0] feat_delta_pressure;
      logic signed [15:0] feat_delta_velocity;
   } req_type;

   typedef struct packed {
      logic [12:0] fused_index;
      logic [12:0] window_mean;
      logic [11:0] window_stddev;
      logic [15:0] alarm_threshold;
   } rsp_type;

   typedef struct packed {
      logic signed [15:0] w0;
      logic signed [15:0] w1;
      logic signed [15:0] w2;
      logic signed [15:0] w3;
      logic signed [15:0] w4;
      logic [15:0]        sigma;
   } cfg_type;
endpackage

FILE: hdl/wsat_if.sv
`timescale 1ns / 1ps
interface wsat_if #(parameter int W = 8) ();
   logic         valid;
   logic         ready;
   logic [W-1:0] data;
   modport source (output valid, output data, input ready);
   modport sink (input valid, input data, output ready);
endinterface

FILE: hdl/wsat_front.sv
`timescale 1ns / 1ps
module wsat_front import wsat_pkg::*; (
   input  logic     clock,
   input  logic     reset,
   input  cfg_type  cfg,
   input  logic     req_valid,
   output logic     req_ready,
   input  req_type  req_data,
   output logic     q_valid,
   input  logic     q_ready,
   output logic [12:0] q_sample
);
   typedef enum logic [1:0] {F_IDLE, F_MUL, F_OUT} fstate_type;
   fstate_type state_ff;
   logic [2:0] idx_ff;
   logic signed [35:0] acc_ff;
   logic signed [31:0] prod_ff;
   logic prod_v_ff;
   req_type item_ff;
   logic [12:0] sample_ff;
   logic signed [15:0] wsel, fsel;
   logic signed [35:0] acc_in;

   always_comb begin
      case (idx_ff)
         REG_W_PRESSURE: begin wsel = cfg.w0; fsel = item_ff.feat_pressure; end
         REG_W_VELOCITY: begin wsel = cfg.w1; fsel = item_ff.feat_velocity; end
         REG_W_SPREAD:   begin wsel = cfg.w2; fsel = item_ff.feat_spread; end
         REG_W_DPRESS:   begin wsel = cfg.w3; fsel = item_ff.feat_delta_pressure; end
         default:        begin wsel = cfg.w4; fsel = item_ff.feat_delta_velocity; end
      endcase
      acc_in = acc_ff + 36'(prod_ff);
   end

   assign req_ready = (state_ff == F_IDLE);
   assign q_valid = (state_ff == F_OUT);
   assign q_sample = sample_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= F_IDLE;
         idx_ff <= '0;
         prod_v_ff <= 1'b0;
      end else begin
         case (state_ff)
            F_IDLE: if (req_valid) begin
               item_ff <= req_data;
               idx_ff <= '0;
               acc_ff <= '0;
               prod_v_ff <= 1'b0;
               state_ff <= F_MUL;
            end
            F_MUL: begin
               if (prod_v_ff) acc_ff <= acc_in;
               if (idx_ff <= REG_W_DVEL) begin
                  prod_ff <= wsel * fsel;
                  prod_v_ff <= 1'b1;
                  idx_ff <= idx_ff + 3'd1;
               end else begin
                  prod_v_ff <= 1'b0;
                  if (acc_in < 0) sample_ff <= '0;
                  else if (acc_in[35:12] > 24'(ONE_Q12)) sample_ff <= ONE_Q12;
                  else sample_ff <= acc_in[24:12];
                  state_ff <= F_OUT;
               end
            end
            F_OUT: if (q_ready) state_ff <= F_IDLE;
            default: state_ff <= F_IDLE;
         endcase
      end
   end
endmodule

FILE: hdl/wsat_fifo.sv
`timescale 1ns / 1ps
module wsat_fifo (
   input  logic        clock,
   input  logic        reset,
   input  logic        in_valid,
   output logic        in_ready,
   input  logic [12:0] in_data,
   output logic        out_valid,
   input  logic        out_ready,
   output logic [12:0] out_data
);
   logic [12:0] mem_ff [2];
   logic wp_ff, rp_ff;
   logic [1:0] cnt_ff;
   logic push, pop;
   assign in_ready = (cnt_ff != 2'd2);
   assign out_valid = (cnt_ff != 2'd0);
   assign out_data = mem_ff[rp_ff];
   assign push = in_valid && in_ready;
   assign pop = out_valid && out_ready;
   always_ff @(posedge clock) begin
      if (push) mem_ff[wp_ff] <= in_data;
      if (reset) begin
         wp_ff <= 1'b0;
         rp_ff <= 1'b0;
         cnt_ff <= '0;
      end else begin
         if (push) wp_ff <= ~wp_ff;
         if (pop) rp_ff <= ~rp_ff;
         cnt_ff <= cnt_ff + 2'(push) - 2'(pop);
      end
   end
endmodule

FILE: hdl/wsat_back.sv
`timescale 1ns / 1ps
module wsat_back import wsat_pkg::*; #(
   parameter int WINDOW_DEPTH = 16
) (
   input  logic        clock,
   input  logic        reset,
   input  logic [15:0] sigma,
   input  logic        q_valid,
   output logic        q_ready,
   input  logic [12:0] q_sample,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output rsp_type     rsp_data
);
   localparam int AW = (WINDOW_DEPTH > 1) ? $clog2(WINDOW_DEPTH) : 1;
   localparam int CW = $clog2(WINDOW_DEPTH + 1);
   localparam int SW = 13 + CW;
   localparam int QW = 26 + CW;
   localparam int NW = QW + CW;
   localparam int VW = 2 * SW;
   localparam int BW = $clog2(VW + 1);
   localparam int RB = 12;

   typedef enum logic [2:0] {B_IDLE, B_WRITE, B_SCAN, B_DIVM, B_DIVV, B_SQRT, B_THR, B_OUT}
      bstate_type;
   bstate_type state_ff;

   logic [12:0] win_mem [WINDOW_DEPTH];
   logic [12:0] rd_ff;
   logic [AW-1:0] slot_ff;
   logic filled_ff;
   logic [CW-1:0] count_ff, scan_ff;
   logic rd_v_ff;
   logic [12:0] sample_ff;
   logic [SW-1:0] sum_ff;
   logic [QW-1:0] sumsq_ff;
   logic [VW-1:0] num_ff;
   logic [VW-1:0] rem_ff;
   logic [VW-1:0] quo_ff;
   logic [VW-1:0] den_ff;
   logic [BW-1:0] bit_ff;
   logic [12:0] mean_ff;
   logic [11:0] var_root_ff;
   logic [23:0] sq_rem_ff;
   logic [23:0] sq_val_ff;
   logic [12:0] sq_res_ff;
   logic [3:0] sq_i_ff;
   logic [27:0] kprod_ff;
   logic [15:0] thr_ff;
   logic [VW-1:0] rem_sh;
   logic [25:0] sq_try;
   logic [25:0] sq_rem_sh;
   logic [16:0] thr_sum;

   always_comb begin
      rem_sh = {rem_ff[VW-2:0], num_ff[VW-1]};
      sq_rem_sh = {sq_rem_ff, sq_val_ff[23:22]};
      sq_try = {11'd0, sq_res_ff, 2'b01};
      thr_sum = 17'(mean_ff) + 17'(kprod_ff[27:12]);
   end

   assign q_ready = (state_ff == B_IDLE);
   assign rsp_valid = (state_ff == B_OUT);
   assign rsp_data = '{fused_index: sample_ff, window_mean: mean_ff,
                       window_stddev: var_root_ff, alarm_threshold: thr_ff};

   always_ff @(posedge clock) begin
      if (state_ff == B_WRITE) win_mem[slot_ff] <= sample_ff;
      rd_ff <= win_mem[scan_ff[AW-1:0]];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= B_IDLE;
         slot_ff <= '0;
         filled_ff <= 1'b0;
         rd_v_ff <= 1'b0;
      end else begin
         case (state_ff)
            B_IDLE: if (q_valid) begin
               sample_ff <= q_sample;
               state_ff <= B_WRITE;
            end
            B_WRITE: begin
               count_ff <= filled_ff ? CW'(WINDOW_DEPTH) : CW'(slot_ff) + CW'(1);
               if (32'(slot_ff) == WINDOW_DEPTH - 1) begin
                  slot_ff <= '0;
                  filled_ff <= 1'b1;
               end else begin
                  slot_ff <= slot_ff + AW'(1);
               end
               scan_ff <= '0;
               sum_ff <= '0;
               sumsq_ff <= '0;
               rd_v_ff <= 1'b0;
               state_ff <= B_SCAN;
            end
            B_SCAN: begin
               if (rd_v_ff) begin
                  sum_ff <= sum_ff + SW'(rd_ff);
                  sumsq_ff <= sumsq_ff + QW'(rd_ff * rd_ff);
               end
               if (scan_ff < count_ff) begin
                  scan_ff <= scan_ff + CW'(1);
                  rd_v_ff <= 1'b1;
               end else if (rd_v_ff) begin
                  rd_v_ff <= 1'b0;
               end else begin
                  num_ff <= VW'(sum_ff);
                  den_ff <= VW'(count_ff);
                  rem_ff <= '0;
                  quo_ff <= '0;
                  bit_ff <= '0;
                  state_ff <= B_DIVM;
               end
            end
            B_DIVM, B_DIVV: begin
               if (32'(bit_ff) < VW) begin
                  num_ff <= num_ff << 1;
                  bit_ff <= bit_ff + BW'(1);
                  if (rem_sh >= den_ff) begin
                     rem_ff <= rem_sh - den_ff;
                     quo_ff <= {quo_ff[VW-2:0], 1'b1};
                  end else begin
                     rem_ff <= rem_sh;
                     quo_ff <= {quo_ff[VW-2:0], 1'b0};
                  end
               end else if (state_ff == B_DIVM) begin
                  mean_ff <= quo_ff[12:0];
                  num_ff <= VW'(NW'(count_ff) * NW'(sumsq_ff)) - VW'(sum_ff * sum_ff);
                  den_ff <= VW'(count_ff * count_ff);
                  rem_ff <= '0;
                  quo_ff <= '0;
                  bit_ff <= '0;
                  state_ff <= B_DIVV;
               end else begin
                  sq_val_ff <= quo_ff[23:0];
                  sq_rem_ff <= '0;
                  sq_res_ff <= '0;
                  sq_i_ff <= '0;
                  state_ff <= B_SQRT;
               end
            end
            B_SQRT: begin
               if (sq_i_ff < 4'(RB)) begin
                  sq_val_ff <= sq_val_ff << 2;
                  sq_i_ff <= sq_i_ff + 4'd1;
                  if (sq_rem_sh >= sq_try) begin
                     sq_rem_ff <= 24'(sq_rem_sh - sq_try);
                     sq_res_ff <= {sq_res_ff[11:0], 1'b1};
                  end else begin
                     sq_rem_ff <= sq_rem_sh[23:0];
                     sq_res_ff <= {sq_res_ff[11:0], 1'b0};
                  end
               end else begin
                  var_root_ff <= sq_res_ff[11:0];
                  kprod_ff <= sigma * sq_res_ff[11:0];
                  state_ff <= B_THR;
               end
            end
            B_THR: begin
               if (thr_sum[16]) thr_ff <= 16'hFFFF;
               else if (thr_sum[15:0] < THRESH_FLOOR) thr_ff <= THRESH_FLOOR;
               else thr_ff <= thr_sum[15:0];
               state_ff <= B_OUT;
            end
            B_OUT: if (rsp_ready) state_ff <= B_IDLE;
            default: state_ff <= B_IDLE;
         endcase
      end
   end
endmodule

FILE: hdl/windowed_stats_adaptive_threshold.sv
`timescale 1ns / 1ps
// channel   direction  payload
// req       in         five signed Q3.12 features
// rsp       out        fused_index, window_mean, window_stddev, alarm_threshold
// csr       in         write enable, index 0..5, 16-bit data
// In the back end, a request passes through the window scan, the two bit-serial
// dividers, the square root and the threshold step. The front end does the five
// multiply-adds serially; a 2-entry queue separates it from the back end. Reset is
// synchronous; it clears control state and loads the register reset values, not
// the datapath registers. Either side may stall; a result holds until taken.
module windowed_stats_adaptive_threshold import wsat_pkg::*; #(
   parameter int WINDOW_DEPTH = 16
) (
   input  logic        clock,
   input  logic        reset,
   wsat_if.sink        req,
   wsat_if.source      rsp,
   input  logic        csr_write,
   input  logic [2:0]  csr_index,
   input  logic [15:0] csr_data
);
   cfg_type cfg_ff;
   logic fq_valid, fq_ready, bq_valid, bq_ready;
   logic [12:0] fq_data, bq_data;
   rsp_type rsp_word;

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff <= '{w0: WEIGHT_RESET, w1: WEIGHT_RESET, w2: WEIGHT_RESET,
                     w3: WEIGHT_RESET, w4: WEIGHT_RESET, sigma: SIGMA_RESET};
      end else if (csr_write) begin
         case (csr_index)
            REG_W_PRESSURE: cfg_ff.w0 <= csr_data;
            REG_W_VELOCITY: cfg_ff.w1 <= csr_data;
            REG_W_SPREAD:   cfg_ff.w2 <= csr_data;
            REG_W_DPRESS:   cfg_ff.w3 <= csr_data;
            REG_W_DVEL:     cfg_ff.w4 <= csr_data;
            REG_SIGMA:      cfg_ff.sigma <= csr_data;
            default: ;
         endcase
      end
   end

   wsat_front u_front (.clock, .reset, .cfg(cfg_ff), .req_valid(req.valid),
      .req_ready(req.ready), .req_data(req_type'(req.data)), .q_valid(fq_valid),
      .q_ready(fq_ready), .q_sample(fq_data));

   wsat_fifo u_fifo (.clock, .reset, .in_valid(fq_valid), .in_ready(fq_ready),
      .in_data(fq_data), .out_valid(bq_valid), .out_ready(bq_ready), .out_data(bq_data));

   wsat_back #(.WINDOW_DEPTH(WINDOW_DEPTH)) u_back (.clock, .reset, .sigma(cfg_ff.sigma),
      .q_valid(bq_valid), .q_ready(bq_ready), .q_sample(bq_data),
      .rsp_valid(rsp.valid), .rsp_ready(rsp.ready), .rsp_data(rsp_word));

   assign rsp.data = rsp_word;
endmodule

FILE: hdl/wsat_checker.sv
`timescale 1ns / 1ps
module wsat_checker (
   input logic        clock,
   input logic        reset,
   input logic        req_ready,
   input logic        rsp_valid,
   input logic        rsp_ready,
   input logic [53:0] rsp_data
);
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_data))
      else $error("result dropped while stalled");
   a_thr_floor: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_data[15:0] >= 16'd819)
      else $error("threshold below floor");
   a_fused_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_data[53:41] <= 13'd4096)
      else $error("sample out of range");
   a_mean_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_data[40:28] <= 13'd4096)
      else $error("mean out of range");
   a_reset_idle: assert property (@(posedge clock)
      $past(reset) |-> !rsp_valid && req_ready)
      else $error("not idle right after reset");
endmodule

bind windowed_stats_adaptive_threshold wsat_checker u_checker (.clock(clock),
   .reset(reset), .req_ready(req.ready),
   .rsp_valid(rsp.valid), .rsp_ready(rsp.ready), .rsp_data(rsp.data));

FILE: tb/sv/windowed_stats_adaptive_threshold_checker.sv
`timescale 1ns / 1ps
module windowed_stats_adaptive_threshold_checker import wsat_pkg::*; #(
   parameter int WINDOW_DEPTH = 16
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   input  logic        req_ready,
   input  req_type     req_data,
   input  logic        rsp_valid,
   input  logic        rsp_ready,
   input  rsp_type     rsp_data,
   input  logic        csr_write,
   input  logic [2:0]  csr_index,
   input  logic [15:0] csr_data,
   output int          fail_count,
   output int          pending
);
   cfg_type     regs;
   logic [12:0] window_samples [WINDOW_DEPTH];
   int          slot;
   bit          wrapped;
   rsp_type     expected_stats [$];

   function automatic longint unsigned floor_sqrt(longint unsigned v);
      longint unsigned root;
      longint unsigned bitv;
      root = 0;
      bitv = 64'd1 << 62;
      while (bitv > v) bitv = bitv >> 2;
      while (bitv != 0) begin
         if (v >= root + bitv) begin
            v = v - (root + bitv);
            root = (root >> 1) + bitv;
         end else begin
            root = root >> 1;
         end
         bitv = bitv >> 2;
      end
      return root;
   endfunction

   function automatic rsp_type predict_stats(req_type r);
      longint          acc;
      longint unsigned sample, total, total_sq, count, mean, variance, sd, thr;
      rsp_type         res;
      acc = longint'(regs.w0) * longint'(r.feat_pressure)
          + longint'(regs.w1) * longint'(r.feat_velocity)
          + longint'(regs.w2) * longint'(r.feat_spread)
          + longint'(regs.w3) * longint'(r.feat_delta_pressure)
          + longint'(regs.w4) * longint'(r.feat_delta_velocity);
      if (acc < 0) sample = 0;
      else begin
         sample = longint'(acc) >>> 12;
         if (sample > ONE_Q12) sample = ONE_Q12;
      end
      window_samples[slot] = sample[12:0];
      count = wrapped ? WINDOW_DEPTH : slot + 1;
      total = 0;
      total_sq = 0;
      for (int i = 0; i < count; i++) begin
         total += window_samples[i];
         total_sq += longint'(window_samples[i]) * window_samples[i];
      end
      mean = total / count;
      variance = (count * total_sq - total * total) / (count * count);
      sd = floor_sqrt(variance);
      thr = mean + ((longint'(regs.sigma) * sd) >> 12);
      if (thr < THRESH_FLOOR) thr = THRESH_FLOOR;
      if (thr > 65535) thr = 65535;
      slot++;
      if (slot >= WINDOW_DEPTH) begin
         slot = 0;
         wrapped = 1;
      end
      res.fused_index = sample[12:0];
      res.window_mean = mean[12:0];
      res.window_stddev = sd[11:0];
      res.alarm_threshold = thr[15:0];
      return res;
   endfunction

   always @(posedge clock) begin
      rsp_type want;
      if (reset) begin
         regs.w0 = WEIGHT_RESET;
         regs.w1 = WEIGHT_RESET;
         regs.w2 = WEIGHT_RESET;
         regs.w3 = WEIGHT_RESET;
         regs.w4 = WEIGHT_RESET;
         regs.sigma = SIGMA_RESET;
         slot = 0;
         wrapped = 0;
         expected_stats.delete();
      end else begin
         if (rsp_valid && rsp_ready) begin
            if (expected_stats.size() == 0) begin
               $display("%0t: unexpected response %h", $time, rsp_data);
               fail_count++;
            end else begin
               want = expected_stats.pop_front();
               if (rsp_data.fused_index !== want.fused_index) begin
                  $display("%0t: fused_index expected %0d actual %0d", $time,
                           want.fused_index, rsp_data.fused_index);
                  fail_count++;
               end
               if (rsp_data.window_mean !== want.window_mean) begin
                  $display("%0t: window_mean expected %0d actual %0d", $time,
                           want.window_mean, rsp_data.window_mean);
                  fail_count++;
               end
               if (rsp_data.window_stddev !== want.window_stddev) begin
                  $display("%0t: window_stddev expected %0d actual %0d", $time,
                           want.window_stddev, rsp_data.window_stddev);
                  fail_count++;
               end
               if (rsp_data.alarm_threshold !== want.alarm_threshold) begin
                  $display("%0t: alarm_threshold expected %0d actual %0d", $time,
                           want.alarm_threshold, rsp_data.alarm_threshold);
                  fail_count++;
               end
            end
         end
         if (req_valid && req_ready) expected_stats.push_back(predict_stats(req_data));
         if (csr_write) begin
            case (csr_index)
               REG_W_PRESSURE: regs.w0 = csr_data;
               REG_W_VELOCITY: regs.w1 = csr_data;
               REG_W_SPREAD:   regs.w2 = csr_data;
               REG_W_DPRESS:   regs.w3 = csr_data;
               REG_W_DVEL:     regs.w4 = csr_data;
               REG_SIGMA:      regs.sigma = csr_data;
               default: ;
            endcase
         end
      end
      pending = expected_stats.size();
   end

   initial begin
      fail_count = 0;
      pending = 0;
   end
endmodule

FILE: tb/sv/windowed_stats_adaptive_threshold_tb.sv
`timescale 1ns / 1ps
module windowed_stats_adaptive_threshold_tb;
   import wsat_pkg::*;

   localparam int CYCLE_LIMIT = 600000;

   logic        clock = 0;
   logic        reset = 1;
   logic        csr_write = 0;
   logic [2:0]  csr_index = '0;
   logic [15:0] csr_data = '0;
   int          fail_count;
   int          pending;
   int          cycles = 0;
   bit          quiet = 0;
   bit          hold_go = 0;
   bit          hold_done = 0;
   int          hold_left = 0;
   int          stall_left = 0;
   logic        req_fire = 0;

   wsat_if #(.W($bits(req_type))) req_ch ();
   wsat_if #(.W($bits(rsp_type))) rsp_ch ();

   windowed_stats_adaptive_threshold #(.WINDOW_DEPTH(16)) dut (
      .clock(clock), .reset(reset), .req(req_ch), .rsp(rsp_ch),
      .csr_write(csr_write), .csr_index(csr_index), .csr_data(csr_data)
   );

   windowed_stats_adaptive_threshold_checker #(.WINDOW_DEPTH(16)) chk (
      .clock(clock), .reset(reset),
      .req_valid(req_ch.valid), .req_ready(req_ch.ready), .req_data(req_ch.data),
      .rsp_valid(rsp_ch.valid), .rsp_ready(rsp_ch.ready), .rsp_data(rsp_ch.data),
      .csr_write(csr_write), .csr_index(csr_index), .csr_data(csr_data),
      .fail_count(fail_count), .pending(pending)
   );

   always #5 clock = ~clock;

   initial begin
      req_ch.valid = 0;
      req_ch.data = '0;
      rsp_ch.ready = 0;
   end

   always @(posedge clock) begin
      req_fire <= req_ch.valid && req_ch.ready;
      cycles <= cycles + 1;
      if (cycles > CYCLE_LIMIT) begin
         $display("Testbench completed WITH ERRORS");
         $finish;
      end
   end

   // receiver: random stalls, one long hold-off
   always @(negedge clock) begin
      if (hold_go && !hold_done) begin
         hold_done <= 1;
         hold_left = 400;
      end
      if (hold_left > 0) begin
         hold_left--;
         rsp_ch.ready <= 0;
      end else if (quiet) begin
         rsp_ch.ready <= 1;
      end else if (stall_left > 0) begin
         stall_left--;
         rsp_ch.ready <= 0;
      end else if ($urandom_range(0, 5) == 0) begin
         stall_left = $urandom_range(0, 9);
         rsp_ch.ready <= 0;
      end else begin
         rsp_ch.ready <= 1;
      end
   end

   task automatic send_request(req_type r);
      req_ch.valid <= 1;
      req_ch.data <= r;
      do @(negedge clock); while (!req_fire);
   endtask

   task automatic pause_sender();
      if (!quiet && $urandom_range(0, 4) == 0) begin
         req_ch.valid <= 0;
         repeat ($urandom_range(1, 10)) @(negedge clock);
      end
   endtask

   task automatic drain();
      req_ch.valid <= 0;
      @(negedge clock);
      while (pending != 0) @(negedge clock);
      repeat (4) @(negedge clock);
   endtask

   task automatic write_weights(logic [15:0] w [5], logic [15:0] sigma);
      csr_write <= 1;
      for (int i = 0; i < 5; i++) begin
         csr_index <= i[2:0];
         csr_data <= w[i];
         @(negedge clock);
      end
      csr_index <= REG_SIGMA;
      csr_data <= sigma;
      @(negedge clock);
      csr_write <= 0;
      @(negedge clock);
   endtask

   function automatic req_type make_request(int mode);
      req_type r;
      logic [15:0] f [5];
      for (int i = 0; i < 5; i++) begin
         if (mode == 0) f[i] = 16'($urandom);
         else f[i] = 16'($urandom_range(0, 12000)) - 16'd2000;
      end
      r.feat_pressure = f[0];
      r.feat_velocity = f[1];
      r.feat_spread = f[2];
      r.feat_delta_pressure = f[3];
      r.feat_delta_velocity = f[4];
      return r;
   endfunction

   function automatic req_type flat_request(logic [15:0] v);
      req_type r;
      r.feat_pressure = v;
      r.feat_velocity = v;
      r.feat_spread = v;
      r.feat_delta_pressure = v;
      r.feat_delta_velocity = v;
      return r;
   endfunction

   initial begin
      logic [15:0] w [5];
      logic [15:0] sigma;
      req_type     r;
      repeat (10) @(negedge clock);
      reset <= 0;
      @(negedge clock);

      // directed: extremes, clamps, window wrap
      send_request(flat_request(16'h7FFF));
      send_request(flat_request(16'h8000));
      send_request(flat_request(16'h0000));
      send_request(flat_request(16'h1000));
      r = flat_request(16'h0000);
      r.feat_pressure = 16'h7FFF;
      send_request(r);
      r = flat_request(16'h0000);
      r.feat_delta_velocity = 16'h8000;
      send_request(r);
      for (int i = 0; i < 14; i++) send_request(make_request(i % 2));
      drain();

      // unknown register indexes are ignored
      csr_write <= 1;
      csr_index <= 3'd6;
      csr_data <= 16'hFFFF;
      @(negedge clock);
      csr_index <= 3'd7;
      @(negedge clock);
      csr_write <= 0;
      @(negedge clock);

      for (int phase = 0; phase < 7; phase++) begin
         case (phase)
            0: begin w = '{16'd4096, 16'd0, 16'd0, 16'd0, 16'd0}; sigma = 16'hFFFF; end
            1: begin w = '{16'h7FFF, 16'h7FFF, 16'h7FFF, 16'h7FFF, 16'h7FFF}; sigma = 16'd0; end
            2: begin w = '{16'h8000, 16'h8000, 16'h8000, 16'h8000, 16'h8000}; sigma = 16'd4096; end
            3: begin w = '{16'h8000, 16'h7FFF, 16'd819, 16'hFCCD, 16'd2048}; sigma = 16'hFFFF; end
            default: begin
               for (int i = 0; i < 5; i++) w[i] = 16'($urandom_range(0, 3000));
               if (phase == 5) w[$urandom_range(0, 4)] = 16'($urandom);
               sigma = 16'($urandom);
            end
         endcase
         write_weights(w, sigma);
         if (phase == 1) hold_go <= 1;
         if (phase == 6) quiet <= 1;
         for (int n = 0; n < 90; n++) begin
            pause_sender();
            send_request(make_request($urandom_range(0, 3) == 0 ? 0 : 1));
         end
         drain();
      end

      repeat (200) @(negedge clock);
      if (fail_count == 0 && pending == 0) begin
         $display("Testbench completed without errors");
      end else begin
         $display("Testbench completed WITH ERRORS");
      end
      $finish;
   end
endmodule

FILE: sim.f
hdl/wsat_pkg.sv
hdl/wsat_if.sv
hdl/wsat_front.sv
hdl/wsat_fifo.sv
hdl/wsat_back.sv
hdl/windowed_stats_adaptive_threshold.sv
hdl/wsat_checker.sv
tb/sv/windowed_stats_adaptive_threshold_checker.sv
tb/sv/windowed_stats_adaptive_threshold_tb.sv
